// ----- hw/rtl/cpt_pkg.sv -----
// Shared widths, constants and types for the circumcircle point test.
package cpt_pkg;

    // Input coordinates
    localparam int IN_W    = 16;
    localparam int COORD_W = 16;
    localparam int N_PTS   = 8;
    localparam int WORD_W  = N_PTS * IN_W;

    // Front-end arithmetic widths
    localparam int DIFF_W  = IN_W + 1;
    localparam int SUM3_W  = IN_W + 2;
    localparam int PROD_W  = IN_W + DIFF_W;
    localparam int SQ1_W   = 2 * IN_W;
    localparam int DEN_W   = 35;
    localparam int DS_W    = DEN_W + 1;
    localparam int NP_W    = SQ1_W + 1 + DIFF_W;
    localparam int NX_W    = NP_W + 2;
    localparam int NUM_W   = 49;

    // Centroid: divide by three through a reciprocal multiply
    localparam int THIRD_MUL = 43691;
    localparam int THIRD_SH  = 17;
    localparam int CEN_PW    = SUM3_W - 1 + 16;

    // Back-end widths
    localparam int UX_W    = NUM_W + 1;
    localparam int DIST_W  = UX_W;
    localparam int LO_W    = 32;
    localparam int HI_W    = DIST_W - LO_W;
    localparam int SQ_W    = 2 * DIST_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int RSQ_W   = 63;
    localparam int CEN_W   = 32;

    localparam logic [RSQ_W-1:0] RSQ_MAX = '1;

    typedef logic signed [IN_W-1:0]  coord_t;
    typedef logic signed [CEN_W-1:0] cen_t;

    // Fields carried alongside the division
    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t qx;
        coord_t qy;
        logic   deg;
        cen_t   cen_x;
        cen_t   cen_y;
    } side_t;

    typedef struct packed {
        side_t             side;
        logic [NUM_W-1:0]  nx_mag;
        logic [NUM_W-1:0]  ny_mag;
        logic              x_neg;
        logic              y_neg;
        logic [DEN_W-1:0]  den_mag;
    } div_in_t;

    typedef struct packed {
        side_t                  side;
        logic signed [UX_W-1:0] ux;
        logic signed [UX_W-1:0] uy;
    } div_out_t;

    typedef struct packed {
        cen_t             center_x;
        cen_t             center_y;
        logic [RSQ_W-1:0] radius_squared;
        logic             inside_res;
        logic             degenerate;
        logic             saturated;
    } result_t;

endpackage

// ----- hw/rtl/cpt_front.sv -----
// Front end: determinant, numerators, centroid and magnitudes over six stages.
module cpt_front #(
    parameter int COORD_W = cpt_pkg::COORD_W
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [cpt_pkg::WORD_W-1:0]   in_word,
    output logic                         out_valid,
    output cpt_pkg::div_in_t             out_data
);

    typedef logic signed [cpt_pkg::DIFF_W-1:0] diff_t;

    typedef struct packed {
        cpt_pkg::coord_t ax, ay, bx, by, cx, cy, qx, qy;
        diff_t d1, d2, d3, e1, e2, e3;
        logic signed [cpt_pkg::SUM3_W-1:0] xs, ys;
    } st1_t;

    typedef struct packed {
        cpt_pkg::coord_t ax, ay, qx, qy;
        logic signed [cpt_pkg::PROD_W-1:0] p1, p2, p3;
        logic [cpt_pkg::SQ1_W-1:0] sq_ax, sq_ay, sq_bx, sq_by, sq_cx, sq_cy;
        diff_t d1, d2, d3, e1, e2, e3;
        logic [cpt_pkg::CEN_PW-1:0] mx, my;
        logic xneg, yneg;
    } st2_t;

    typedef struct packed {
        cpt_pkg::coord_t ax, ay, qx, qy;
        logic signed [cpt_pkg::DS_W-1:0] den;
        logic [cpt_pkg::SQ1_W-1:0] sa, sb, sc;
        diff_t d1, d2, d3, e1, e2, e3;
        cpt_pkg::cen_t cen_x, cen_y;
    } st3_t;

    typedef struct packed {
        cpt_pkg::coord_t ax, ay, qx, qy;
        logic signed [cpt_pkg::DS_W-1:0] den;
        logic signed [cpt_pkg::NP_W-1:0] n1, n2, n3, m1, m2, m3;
        cpt_pkg::cen_t cen_x, cen_y;
    } st4_t;

    typedef struct packed {
        cpt_pkg::coord_t ax, ay, qx, qy;
        logic signed [cpt_pkg::DS_W-1:0] den;
        logic signed [cpt_pkg::NX_W-1:0] nx, ny;
        cpt_pkg::cen_t cen_x, cen_y;
    } st5_t;

    // Sign-extend the low COORD_W bits of a coordinate
    function automatic cpt_pkg::coord_t sext(input logic [cpt_pkg::IN_W-1:0] v);
        return cpt_pkg::IN_W'(signed'(v[COORD_W-1:0]));
    endfunction

    st1_t s1_next, s1_reg;
    st2_t s2_next, s2_reg;
    st3_t s3_next, s3_reg;
    st4_t s4_next, s4_reg;
    st5_t s5_next, s5_reg;
    cpt_pkg::div_in_t s6_next, s6_reg;
    logic [5:0] vld_reg;

    logic signed [cpt_pkg::SUM3_W-1:0] xs_abs, ys_abs;
    logic signed [cpt_pkg::DS_W-1:0]   dsum;
    logic [cpt_pkg::CEN_W-1:0]         cmx, cmy;
    logic signed [cpt_pkg::NX_W-1:0]   nx_abs, ny_abs;
    logic signed [cpt_pkg::DS_W-1:0]   den_abs;

    // Stage 1: unpack, differences, coordinate sums
    always_comb begin
        s1_next.ax = sext(in_word[0*cpt_pkg::IN_W +: cpt_pkg::IN_W]);
        s1_next.ay = sext(in_word[1*cpt_pkg::IN_W +: cpt_pkg::IN_W]);
        s1_next.bx = sext(in_word[2*cpt_pkg::IN_W +: cpt_pkg::IN_W]);
        s1_next.by = sext(in_word[3*cpt_pkg::IN_W +: cpt_pkg::IN_W]);
        s1_next.cx = sext(in_word[4*cpt_pkg::IN_W +: cpt_pkg::IN_W]);
        s1_next.cy = sext(in_word[5*cpt_pkg::IN_W +: cpt_pkg::IN_W]);
        s1_next.qx = sext(in_word[6*cpt_pkg::IN_W +: cpt_pkg::IN_W]);
        s1_next.qy = sext(in_word[7*cpt_pkg::IN_W +: cpt_pkg::IN_W]);
        s1_next.d1 = s1_next.by - s1_next.cy;
        s1_next.d2 = s1_next.cy - s1_next.ay;
        s1_next.d3 = s1_next.ay - s1_next.by;
        s1_next.e1 = s1_next.cx - s1_next.bx;
        s1_next.e2 = s1_next.ax - s1_next.cx;
        s1_next.e3 = s1_next.bx - s1_next.ax;
        s1_next.xs = s1_next.ax + s1_next.bx + s1_next.cx;
        s1_next.ys = s1_next.ay + s1_next.by + s1_next.cy;
    end

    // Stage 2: determinant terms, squares, centroid multiply
    always_comb begin
        xs_abs = s1_reg.xs[cpt_pkg::SUM3_W-1] ? -s1_reg.xs : s1_reg.xs;
        ys_abs = s1_reg.ys[cpt_pkg::SUM3_W-1] ? -s1_reg.ys : s1_reg.ys;
        s2_next.ax = s1_reg.ax;
        s2_next.ay = s1_reg.ay;
        s2_next.qx = s1_reg.qx;
        s2_next.qy = s1_reg.qy;
        s2_next.p1 = s1_reg.ax * s1_reg.d1;
        s2_next.p2 = s1_reg.bx * s1_reg.d2;
        s2_next.p3 = s1_reg.cx * s1_reg.d3;
        s2_next.sq_ax = s1_reg.ax * s1_reg.ax;
        s2_next.sq_ay = s1_reg.ay * s1_reg.ay;
        s2_next.sq_bx = s1_reg.bx * s1_reg.bx;
        s2_next.sq_by = s1_reg.by * s1_reg.by;
        s2_next.sq_cx = s1_reg.cx * s1_reg.cx;
        s2_next.sq_cy = s1_reg.cy * s1_reg.cy;
        s2_next.d1 = s1_reg.d1;
        s2_next.d2 = s1_reg.d2;
        s2_next.d3 = s1_reg.d3;
        s2_next.e1 = s1_reg.e1;
        s2_next.e2 = s1_reg.e2;
        s2_next.e3 = s1_reg.e3;
        s2_next.mx = cpt_pkg::CEN_PW'(xs_abs[cpt_pkg::SUM3_W-2:0])
                     * cpt_pkg::CEN_PW'(cpt_pkg::THIRD_MUL);
        s2_next.my = cpt_pkg::CEN_PW'(ys_abs[cpt_pkg::SUM3_W-2:0])
                     * cpt_pkg::CEN_PW'(cpt_pkg::THIRD_MUL);
        s2_next.xneg = s1_reg.xs[cpt_pkg::SUM3_W-1];
        s2_next.yneg = s1_reg.ys[cpt_pkg::SUM3_W-1];
    end

    // Stage 3: doubled determinant, squared norms, signed centroid
    always_comb begin
        dsum = cpt_pkg::DS_W'(s2_reg.p1) + cpt_pkg::DS_W'(s2_reg.p2)
               + cpt_pkg::DS_W'(s2_reg.p3);
        cmx = cpt_pkg::CEN_W'(s2_reg.mx >> cpt_pkg::THIRD_SH);
        cmy = cpt_pkg::CEN_W'(s2_reg.my >> cpt_pkg::THIRD_SH);
        s3_next.ax = s2_reg.ax;
        s3_next.ay = s2_reg.ay;
        s3_next.qx = s2_reg.qx;
        s3_next.qy = s2_reg.qy;
        s3_next.den = dsum <<< 1;
        s3_next.sa = s2_reg.sq_ax + s2_reg.sq_ay;
        s3_next.sb = s2_reg.sq_bx + s2_reg.sq_by;
        s3_next.sc = s2_reg.sq_cx + s2_reg.sq_cy;
        s3_next.d1 = s2_reg.d1;
        s3_next.d2 = s2_reg.d2;
        s3_next.d3 = s2_reg.d3;
        s3_next.e1 = s2_reg.e1;
        s3_next.e2 = s2_reg.e2;
        s3_next.e3 = s2_reg.e3;
        s3_next.cen_x = s2_reg.xneg ? -signed'(cmx) : signed'(cmx);
        s3_next.cen_y = s2_reg.yneg ? -signed'(cmy) : signed'(cmy);
    end

    // Stage 4: numerator products
    always_comb begin
        s4_next.ax = s3_reg.ax;
        s4_next.ay = s3_reg.ay;
        s4_next.qx = s3_reg.qx;
        s4_next.qy = s3_reg.qy;
        s4_next.den = s3_reg.den;
        s4_next.n1 = $signed({1'b0, s3_reg.sa}) * s3_reg.d1;
        s4_next.n2 = $signed({1'b0, s3_reg.sb}) * s3_reg.d2;
        s4_next.n3 = $signed({1'b0, s3_reg.sc}) * s3_reg.d3;
        s4_next.m1 = $signed({1'b0, s3_reg.sa}) * s3_reg.e1;
        s4_next.m2 = $signed({1'b0, s3_reg.sb}) * s3_reg.e2;
        s4_next.m3 = $signed({1'b0, s3_reg.sc}) * s3_reg.e3;
        s4_next.cen_x = s3_reg.cen_x;
        s4_next.cen_y = s3_reg.cen_y;
    end

    // Stage 5: numerator sums
    always_comb begin
        s5_next.ax = s4_reg.ax;
        s5_next.ay = s4_reg.ay;
        s5_next.qx = s4_reg.qx;
        s5_next.qy = s4_reg.qy;
        s5_next.den = s4_reg.den;
        s5_next.nx = cpt_pkg::NX_W'(s4_reg.n1) + cpt_pkg::NX_W'(s4_reg.n2)
                     + cpt_pkg::NX_W'(s4_reg.n3);
        s5_next.ny = cpt_pkg::NX_W'(s4_reg.m1) + cpt_pkg::NX_W'(s4_reg.m2)
                     + cpt_pkg::NX_W'(s4_reg.m3);
        s5_next.cen_x = s4_reg.cen_x;
        s5_next.cen_y = s4_reg.cen_y;
    end

    // Stage 6: magnitudes and quotient signs for the divider
    always_comb begin
        nx_abs  = s5_reg.nx[cpt_pkg::NX_W-1] ? -s5_reg.nx : s5_reg.nx;
        ny_abs  = s5_reg.ny[cpt_pkg::NX_W-1] ? -s5_reg.ny : s5_reg.ny;
        den_abs = s5_reg.den[cpt_pkg::DS_W-1] ? -s5_reg.den : s5_reg.den;
        s6_next.side.ax    = s5_reg.ax;
        s6_next.side.ay    = s5_reg.ay;
        s6_next.side.qx    = s5_reg.qx;
        s6_next.side.qy    = s5_reg.qy;
        s6_next.side.deg   = (s5_reg.den == '0);
        s6_next.side.cen_x = s5_reg.cen_x;
        s6_next.side.cen_y = s5_reg.cen_y;
        s6_next.nx_mag  = nx_abs[cpt_pkg::NUM_W-1:0];
        s6_next.ny_mag  = ny_abs[cpt_pkg::NUM_W-1:0];
        s6_next.x_neg   = s5_reg.nx[cpt_pkg::NX_W-1] ^ s5_reg.den[cpt_pkg::DS_W-1];
        s6_next.y_neg   = s5_reg.ny[cpt_pkg::NX_W-1] ^ s5_reg.den[cpt_pkg::DS_W-1];
        s6_next.den_mag = den_abs[cpt_pkg::DEN_W-1:0];
    end

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_data  = s6_reg;

endmodule

// ----- hw/rtl/cpt_div.sv -----
// Pipelined restoring divider, two lanes over one divisor, rounded to nearest.
module cpt_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  cpt_pkg::div_in_t   in_data,
    output logic               out_valid,
    output cpt_pkg::div_out_t  out_data
);

    localparam int NW = cpt_pkg::NUM_W;
    localparam int DW = cpt_pkg::DEN_W;

    // One quotient bit: shift in the next numerator bit, subtract if it fits
    function automatic logic [DW+NW-1:0] div_step(
        input logic [DW-1:0] rem,
        input logic [NW-1:0] nq,
        input logic [DW-1:0] den
    );
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_n;
        trial = {rem, nq[NW-1]};
        ge    = (trial >= {1'b0, den});
        rem_n = ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
        return {rem_n, nq[NW-2:0], ge};
    endfunction

    // Step pipeline: stage 0 is the load, stages 1..NW each resolve one bit
    logic [NW:0]           vld_reg;
    cpt_pkg::side_t        side_reg [NW+1];
    logic [DW-1:0]         den_reg  [NW+1];
    logic                  xneg_reg [NW+1];
    logic                  yneg_reg [NW+1];
    logic [DW-1:0]         remx_reg [NW+1];
    logic [NW-1:0]         nqx_reg  [NW+1];
    logic [DW-1:0]         remy_reg [NW+1];
    logic [NW-1:0]         nqy_reg  [NW+1];
    logic [DW+NW-1:0]      stepx_next [1:NW];
    logic [DW+NW-1:0]      stepy_next [1:NW];

    // Rounding and sign stages
    logic                       r1_vld_reg, r2_vld_reg;
    cpt_pkg::side_t             r1_side_reg;
    logic [cpt_pkg::UX_W-1:0]   r1_qx_reg, r1_qy_reg;
    logic                       r1_xneg_reg, r1_yneg_reg;
    logic                       incx, incy;
    cpt_pkg::div_out_t          r2_reg;

    always_comb begin
        for (int k = 1; k <= NW; k++) begin
            stepx_next[k] = div_step(remx_reg[k-1], nqx_reg[k-1], den_reg[k-1]);
            stepy_next[k] = div_step(remy_reg[k-1], nqy_reg[k-1], den_reg[k-1]);
        end
    end

    // Round half up on the magnitude: remainder at least half the divisor
    always_comb begin
        incx = ({remx_reg[NW], 1'b0} >= {1'b0, den_reg[NW]});
        incy = ({remy_reg[NW], 1'b0} >= {1'b0, den_reg[NW]});
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            r1_vld_reg <= 1'b0;
            r2_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg    <= {vld_reg[NW-1:0], in_valid};
            r1_vld_reg <= vld_reg[NW];
            r2_vld_reg <= r1_vld_reg;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_data.side;
            den_reg[0]  <= in_data.den_mag;
            xneg_reg[0] <= in_data.x_neg;
            yneg_reg[0] <= in_data.y_neg;
            remx_reg[0] <= '0;
            nqx_reg[0]  <= in_data.nx_mag;
            remy_reg[0] <= '0;
            nqy_reg[0]  <= in_data.ny_mag;
            for (int k = 1; k <= NW; k++) begin
                side_reg[k] <= side_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                xneg_reg[k] <= xneg_reg[k-1];
                yneg_reg[k] <= yneg_reg[k-1];
                {remx_reg[k], nqx_reg[k]} <= stepx_next[k];
                {remy_reg[k], nqy_reg[k]} <= stepy_next[k];
            end
            r1_side_reg <= side_reg[NW];
            r1_qx_reg   <= cpt_pkg::UX_W'(nqx_reg[NW]) + cpt_pkg::UX_W'(incx);
            r1_qy_reg   <= cpt_pkg::UX_W'(nqy_reg[NW]) + cpt_pkg::UX_W'(incy);
            r1_xneg_reg <= xneg_reg[NW];
            r1_yneg_reg <= yneg_reg[NW];
            r2_reg.side <= r1_side_reg;
            r2_reg.ux   <= r1_xneg_reg ? -signed'(r1_qx_reg) : signed'(r1_qx_reg);
            r2_reg.uy   <= r1_yneg_reg ? -signed'(r1_qy_reg) : signed'(r1_qy_reg);
        end
    end

    assign out_valid = r2_vld_reg;
    assign out_data  = r2_reg;

endmodule

// ----- hw/rtl/cpt_back.sv -----
// Back end: clipping, squared distances, inside compare and result select.
module cpt_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  cpt_pkg::div_out_t  in_data,
    output logic               out_valid,
    output cpt_pkg::result_t   out_data
);

    localparam int DW = cpt_pkg::DIST_W;
    localparam int LW = cpt_pkg::LO_W;
    localparam int HW = cpt_pkg::HI_W;

    typedef struct packed {
        logic          deg;
        cpt_pkg::cen_t cen_x, cen_y;
        cpt_pkg::cen_t clx, cly;
        logic          csat;
    } hdr_t;

    typedef struct packed {
        logic [2*HW-1:0]  hh;
        logic [HW+LW-1:0] hl;
        logic [2*LW-1:0]  ll;
    } part_t;

    typedef struct packed {
        hdr_t hdr;
        logic signed [DW:0] drx, dry, dqx, dqy;
    } st1_t;

    typedef struct packed {
        hdr_t hdr;
        logic [DW-1:0] mrx, mry, mqx, mqy;
    } st2_t;

    typedef struct packed {
        hdr_t hdr;
        part_t prx, pry, pqx, pqy;
    } st3_t;

    typedef struct packed {
        hdr_t hdr;
        logic [cpt_pkg::SQ_W-1:0] srx, sry, sqx, sqy;
    } st4_t;

    typedef struct packed {
        hdr_t hdr;
        logic [cpt_pkg::SUM_W-1:0] r2, q2;
    } st5_t;

    // Saturate a quotient to 32 bits
    function automatic cpt_pkg::cen_t clip32(input logic signed [cpt_pkg::UX_W-1:0] v,
                                             output logic ovf);
        ovf = (v[cpt_pkg::UX_W-1:cpt_pkg::CEN_W-1] != '0)
              && (v[cpt_pkg::UX_W-1:cpt_pkg::CEN_W-1] != '1);
        if (!ovf) begin
            return v[cpt_pkg::CEN_W-1:0];
        end
        return v[cpt_pkg::UX_W-1] ? {1'b1, {(cpt_pkg::CEN_W-1){1'b0}}}
                                  : {1'b0, {(cpt_pkg::CEN_W-1){1'b1}}};
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW:0] v);
        logic signed [DW:0] a;
        a = v[DW] ? -v : v;
        return a[DW-1:0];
    endfunction

    // Split the square into three narrow products
    function automatic part_t split_sq(input logic [DW-1:0] m);
        part_t p;
        p.hh = m[DW-1:LW] * m[DW-1:LW];
        p.hl = m[DW-1:LW] * m[LW-1:0];
        p.ll = m[LW-1:0] * m[LW-1:0];
        return p;
    endfunction

    function automatic logic [cpt_pkg::SQ_W-1:0] join_sq(input part_t p);
        return (cpt_pkg::SQ_W'(p.hh) << (2*LW)) + (cpt_pkg::SQ_W'(p.hl) << (LW+1))
               + cpt_pkg::SQ_W'(p.ll);
    endfunction

    st1_t s1_next, s1_reg;
    st2_t s2_reg;
    st3_t s3_reg;
    st4_t s4_reg;
    st5_t s5_reg;
    cpt_pkg::result_t s6_next, s6_reg;
    logic [5:0] vld_reg;
    logic ovx, ovy, rsq_ovf;

    // Stage 1: clip the center, offsets to first vertex and to query
    always_comb begin
        s1_next.hdr.deg   = in_data.side.deg;
        s1_next.hdr.cen_x = in_data.side.cen_x;
        s1_next.hdr.cen_y = in_data.side.cen_y;
        s1_next.hdr.clx   = clip32(in_data.ux, ovx);
        s1_next.hdr.cly   = clip32(in_data.uy, ovy);
        s1_next.hdr.csat  = ovx | ovy;
        s1_next.drx = (DW+1)'(in_data.ux) - (DW+1)'(in_data.side.ax);
        s1_next.dry = (DW+1)'(in_data.uy) - (DW+1)'(in_data.side.ay);
        s1_next.dqx = (DW+1)'(in_data.ux) - (DW+1)'(in_data.side.qx);
        s1_next.dqy = (DW+1)'(in_data.uy) - (DW+1)'(in_data.side.qy);
    end

    // Stage 6: inside compare, radius saturation, degenerate override
    always_comb begin
        rsq_ovf = (s5_reg.r2[cpt_pkg::SUM_W-1:cpt_pkg::RSQ_W] != '0);
        if (s5_reg.hdr.deg) begin
            s6_next.center_x       = s5_reg.hdr.cen_x;
            s6_next.center_y       = s5_reg.hdr.cen_y;
            s6_next.radius_squared = cpt_pkg::RSQ_MAX;
            s6_next.inside_res     = 1'b1;
            s6_next.degenerate     = 1'b1;
            s6_next.saturated      = 1'b0;
        end else begin
            s6_next.center_x       = s5_reg.hdr.clx;
            s6_next.center_y       = s5_reg.hdr.cly;
            s6_next.radius_squared = rsq_ovf ? cpt_pkg::RSQ_MAX
                                             : s5_reg.r2[cpt_pkg::RSQ_W-1:0];
            s6_next.inside_res     = (s5_reg.q2 <= s5_reg.r2);
            s6_next.degenerate     = 1'b0;
            s6_next.saturated      = s5_reg.hdr.csat | rsq_ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    // Stages 2..5: magnitudes, partial products, squares, sums
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg     <= s1_next;
            s2_reg.hdr <= s1_reg.hdr;
            s2_reg.mrx <= mag(s1_reg.drx);
            s2_reg.mry <= mag(s1_reg.dry);
            s2_reg.mqx <= mag(s1_reg.dqx);
            s2_reg.mqy <= mag(s1_reg.dqy);
            s3_reg.hdr <= s2_reg.hdr;
            s3_reg.prx <= split_sq(s2_reg.mrx);
            s3_reg.pry <= split_sq(s2_reg.mry);
            s3_reg.pqx <= split_sq(s2_reg.mqx);
            s3_reg.pqy <= split_sq(s2_reg.mqy);
            s4_reg.hdr <= s3_reg.hdr;
            s4_reg.srx <= join_sq(s3_reg.prx);
            s4_reg.sry <= join_sq(s3_reg.pry);
            s4_reg.sqx <= join_sq(s3_reg.pqx);
            s4_reg.sqy <= join_sq(s3_reg.pqy);
            s5_reg.hdr <= s4_reg.hdr;
            s5_reg.r2  <= cpt_pkg::SUM_W'(s4_reg.srx) + cpt_pkg::SUM_W'(s4_reg.sry);
            s5_reg.q2  <= cpt_pkg::SUM_W'(s4_reg.sqx) + cpt_pkg::SUM_W'(s4_reg.sqy);
            s6_reg     <= s6_next;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_data  = s6_reg;

endmodule

// ----- hw/rtl/circumcircle_point_test.sv -----
// Top level of the circumcircle point test: input skid, pipeline, output word.
//
//  channel  dir  word layout (lowest bits first)
//  s_axis   in   tdata: vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
//                       vertex_c_x, vertex_c_y, query_x, query_y (16 b each)
//  m_axis   out  tdata: center_x, center_y, radius_squared, inside_res
//                tuser: degenerate, saturated
//
// One word per cycle sustained while m_axis is ready; the 49-stage restoring divider
// resolves one quotient bit per stage.
// Reset is synchronous, active low, and clears only the valid bits.
// A stall on m_axis freezes the whole pipeline; a one-word skid register on
// s_axis catches the word taken in the stall cycle, so s_axis_tready is registered.
module circumcircle_point_test #(
    parameter int COORD_W = cpt_pkg::COORD_W
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
    // query_x, query_y
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // center_x, center_y, radius_squared, inside_res
    output logic [127:0] m_axis_tdata,
    // degenerate, saturated
    output logic [1:0]   m_axis_tuser
);

    logic                        en;
    logic                        s_acc;
    logic                        skid_valid_reg, skid_valid_next;
    logic [cpt_pkg::WORD_W-1:0]  skid_data_reg;
    logic                        front_in_valid;
    logic [cpt_pkg::WORD_W-1:0]  front_in_word;
    logic                        front_valid, div_valid;
    cpt_pkg::div_in_t            front_data;
    cpt_pkg::div_out_t           div_data;
    cpt_pkg::result_t            res;

    // Pipeline moves unless a finished word is held at the output
    assign en    = !m_axis_tvalid || m_axis_tready;
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !skid_valid_reg;

    // Skid: park the word accepted while the pipeline is stalled
    always_comb begin
        skid_valid_next = skid_valid_reg;
        if (en) begin
            skid_valid_next = 1'b0;
        end else if (s_acc) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_acc) begin
            skid_data_reg <= s_axis_tdata;
        end
    end

    assign front_in_valid = skid_valid_reg || s_acc;
    assign front_in_word  = skid_valid_reg ? skid_data_reg : s_axis_tdata;

    cpt_front #(
        .COORD_W   (COORD_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_in_valid),
        .in_word   (front_in_word),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    cpt_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    cpt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .out_valid (m_axis_tvalid),
        .out_data  (res)
    );

    assign m_axis_tdata = {res.inside_res, res.radius_squared, res.center_y, res.center_x};
    assign m_axis_tuser = {res.saturated, res.degenerate};

endmodule

// ----- bench/tb_circumcircle_point_test.sv -----
// Self-checking bench for the circumcircle point test: stream stimulus, predictor, checker.
module tb_circumcircle_point_test;

    localparam int LATENCY   = 64;
    localparam int MAX_CYCLE = 600000;
    localparam int HOLD_LEN  = 300;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    cpt_pkg::result_t expected_circles[$];
    int      mismatches;
    int      words_sent;
    int      words_checked;
    int      n_degenerate;
    int      n_inside;
    int      n_saturated;
    int      cycle_count;
    bit      calm;
    bit      hold_trigger;
    int      hold_left;

    circumcircle_point_test uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 12-unit clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Quotient rounded to nearest, ties away from zero, clipped at 2^62
    function automatic longint round_quot(input longint num, input longint den);
        longint mn, md, q, rem;
        mn  = (num < 0) ? -num : num;
        md  = (den < 0) ? -den : den;
        q   = mn / md;
        rem = mn % md;
        if (rem >= md - rem) q++;
        if (q > 64'sh4000000000000000) q = 64'sh4000000000000000;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic cpt_pkg::cen_t clip_center(input longint v, inout bit sat);
        if (v > 64'sh7FFFFFFF) begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sh80000000) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return cpt_pkg::cen_t'(v);
    endfunction

    // Expected circumcircle result for one packed input word
    function automatic cpt_pkg::result_t predict_circle(input logic [127:0] w);
        longint p[8];
        longint ax, ay, bx, by, cx, cy, qx, qy;
        longint d, sa, sb, sc, nx, ny, ux, uy;
        logic signed [127:0] dx, dy, r2, q2;
        cpt_pkg::result_t r;
        bit sat;
        for (int i = 0; i < 8; i++) p[i] = longint'(signed'(w[16*i +: 16]));
        ax = p[0]; ay = p[1]; bx = p[2]; by = p[3];
        cx = p[4]; cy = p[5]; qx = p[6]; qy = p[7];
        sat = 1'b0;
        d = 2 * (ax * (by - cy) + bx * (cy - ay) + cx * (ay - by));
        if (d == 0) begin
            r.center_x       = cpt_pkg::cen_t'((ax + bx + cx) / 3);
            r.center_y       = cpt_pkg::cen_t'((ay + by + cy) / 3);
            r.radius_squared = cpt_pkg::RSQ_MAX;
            r.inside_res     = 1'b1;
            r.degenerate     = 1'b1;
            r.saturated      = 1'b0;
            return r;
        end
        sa = ax * ax + ay * ay;
        sb = bx * bx + by * by;
        sc = cx * cx + cy * cy;
        nx = sa * (by - cy) + sb * (cy - ay) + sc * (ay - by);
        ny = sa * (cx - bx) + sb * (ax - cx) + sc * (bx - ax);
        ux = round_quot(nx, d);
        uy = round_quot(ny, d);
        dx = 128'(ux - ax);
        dy = 128'(uy - ay);
        r2 = dx * dx + dy * dy;
        dx = 128'(ux - qx);
        dy = 128'(uy - qy);
        q2 = dx * dx + dy * dy;
        r.center_x = clip_center(ux, sat);
        r.center_y = clip_center(uy, sat);
        if (r2 > 128'(cpt_pkg::RSQ_MAX)) begin
            sat = 1'b1;
            r.radius_squared = cpt_pkg::RSQ_MAX;
        end else begin
            r.radius_squared = r2[cpt_pkg::RSQ_W-1:0];
        end
        r.inside_res = (q2 <= r2);
        r.degenerate = 1'b0;
        r.saturated  = sat;
        return r;
    endfunction

    function automatic logic [127:0] pack_word(input int v[8]);
        logic [127:0] w;
        for (int i = 0; i < 8; i++) w[16*i +: 16] = 16'(v[i]);
        return w;
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 36);
    endfunction

    // Offer one word, wait for the handshake, record its expectation
    task automatic send_word(input logic [127:0] w);
        s_axis_tdata  <= w;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        expected_circles.push_back(predict_circle(w));
        words_sent++;
        if (idle_now()) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while (idle_now());
        end
    endtask

    task automatic send_coords(input int ax, ay, bx, by, cx, cy, qx, qy);
        int v[8];
        v = '{ax, ay, bx, by, cx, cy, qx, qy};
        send_word(pack_word(v));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_circles.size() != 0) @(posedge aclk);
    endtask

    // Field extremes, right angles, ties and huge centers
    task automatic test_directed();
        send_coords(0, 0, 256, 0, 0, 256, 128, 128);
        send_coords(0, 0, 256, 0, 0, 256, 1000, 1000);
        send_coords(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0);
        send_coords(32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768);
        send_coords(-32768, -32768, 32767, 32767, 32767, 32766, 32767, -32768);
        send_coords(-32768, 32767, 32767, -32768, 32766, -32768, 0, 0);
        send_coords(0, 0, 1, 0, 0, 1, 1, 1);
        send_coords(0, 0, 3, 0, 0, 1, 2, 0);
        send_coords(1, 1, -1, 2, 2, -3, -32768, 32767);
        send_coords(100, 200, 300, 400, -500, 600, 100, 200);
        send_coords(-32768, 0, 32767, 0, 0, 32767, 0, -32768);
        send_coords(-1, -1, -1, -1, -1, -1, -1, -1);
        send_coords(0, 0, 0, 0, 0, 0, 32767, 32767);
        send_coords(1, 2, 3, 4, 5, 6, 0, 0);
        send_coords(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0);
        send_coords(32767, 32767, 32767, 32767, 32767, 32767, 0, 0);
        send_coords(-7, -7, 0, 0, 7, 7, 1, 1);
        send_coords(-32768, 5, 32767, 5, 0, 5, 0, 5);
        send_coords(4, 4, 4, 4, 100, -9, 4, 4);
        send_coords(256, 0, -256, 0, 0, 256, 0, -256);
        send_coords(256, 0, -256, 0, 0, 256, 0, -257);
    endtask

    // Mixed random triangles: full range, local, collinear, near-collinear and queries near a vertex
    task automatic test_random(input int count);
        int v[8];
        int dx, dy, k, m;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(5))
                0, 1: for (int i = 0; i < 8; i++) v[i] = $urandom_range(65535);
                2: begin
                    v[0] = $urandom_range(2000) - 1000;
                    v[1] = $urandom_range(2000) - 1000;
                    for (int i = 2; i < 8; i++)
                        v[i] = v[i % 2] + $urandom_range(1200) - 600;
                end
                3: begin
                    dx = $urandom_range(200) - 100;
                    dy = $urandom_range(200) - 100;
                    k  = $urandom_range(100) - 50;
                    m  = $urandom_range(100) - 50;
                    v[0] = $urandom_range(20000) - 10000;
                    v[1] = $urandom_range(20000) - 10000;
                    v[2] = v[0] + k * dx; v[3] = v[1] + k * dy;
                    v[4] = v[0] + m * dx; v[5] = v[1] + m * dy;
                    v[6] = $urandom_range(65535); v[7] = $urandom_range(65535);
                end
                4: begin
                    v[0] = $urandom_range(65535) - 32768;
                    v[1] = $urandom_range(65535) - 32768;
                    v[2] = -v[0]; v[3] = -v[1];
                    v[4] = v[2] + $urandom_range(2) - 1;
                    v[5] = v[3] + $urandom_range(2) - 1;
                    if (v[4] > 32767) v[4] = 32767;
                    if (v[5] > 32767) v[5] = 32767;
                    v[6] = $urandom_range(65535); v[7] = $urandom_range(65535);
                end
                default: begin
                    for (int i = 0; i < 6; i++) v[i] = $urandom_range(4000) - 2000;
                    k = 2 * $urandom_range(2);
                    v[6] = v[k] + $urandom_range(2) - 1;
                    v[7] = v[k + 1] + $urandom_range(2) - 1;
                end
            endcase
            send_word(pack_word(v));
        end
    endtask

    // Receiver stalls for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        calm = 1'b1;
        hold_trigger <= 1'b1;
        @(posedge aclk);
        hold_trigger <= 1'b0;
        test_random(120);
        calm = 1'b0;
        wait_drained();
    endtask

    // Back-to-back words with no idling on either side
    task automatic test_streaming();
        calm = 1'b1;
        test_random(250);
        calm = 1'b0;
    endtask

    // Receiver ready: random idling, or a counted hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end else if (hold_trigger) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_LEN;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 36);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        cpt_pkg::result_t exp_r;
        cpt_pkg::result_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.center_x       = m_axis_tdata[31:0];
            got.center_y       = m_axis_tdata[63:32];
            got.radius_squared = m_axis_tdata[126:64];
            got.inside_res     = m_axis_tdata[127];
            got.degenerate     = m_axis_tuser[0];
            got.saturated      = m_axis_tuser[1];
            if (expected_circles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata);
            end else begin
                exp_r = expected_circles.pop_front();
                words_checked++;
                n_degenerate += exp_r.degenerate;
                n_inside     += exp_r.inside_res;
                n_saturated  += exp_r.saturated;
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"word %0d: cx %h/%h cy %h/%h rsq %h/%h in %b/%b ",
                                  "deg %b/%b sat %b/%b (exp/got)"}, words_checked,
                                 exp_r.center_x, got.center_x, exp_r.center_y, got.center_y,
                                 exp_r.radius_squared, got.radius_squared,
                                 exp_r.inside_res, got.inside_res,
                                 exp_r.degenerate, got.degenerate,
                                 exp_r.saturated, got.saturated);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL circumcircle_point_test");
            $finish;
        end
    end

    // Test sequence
    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        hold_trigger  = 1'b0;
        calm          = 1'b0;
        mismatches    = 0;
        words_sent    = 0;
        words_checked = 0;
        n_degenerate  = 0;
        n_inside      = 0;
        n_saturated   = 0;
        cycle_count   = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        wait_drained();
        test_random(700);
        test_backpressure();
        test_streaming();
        test_random(800);
        wait_drained();
        repeat (LATENCY + 16) @(posedge aclk);

        $display("%0d words checked: %0d degenerate, %0d inside, %0d saturated",
                 words_checked, n_degenerate, n_inside, n_saturated);
        $display("covered field extremes, collinear and near-collinear triangles, stalls");
        if (mismatches == 0 && expected_circles.size() == 0) begin
            $display("PASS circumcircle_point_test");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_circles.size());
            $display("FAIL circumcircle_point_test");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/cpt_pkg.sv
hw/rtl/cpt_front.sv
hw/rtl/cpt_div.sv
hw/rtl/cpt_back.sv
hw/rtl/circumcircle_point_test.sv
bench/tb_circumcircle_point_test.sv
